### hw/rtl/qwti_pkg.sv
// shared widths, word layout and opcodes of the quarter-wave table interpolator
`timescale 1ns / 1ps

package qwti_pkg;

    localparam int OPCODE_W = 1;
    localparam int ADDR_W   = 9;
    localparam int SAMPLE_W = 16;
    localparam int PHASE_W  = 24;

    // input word layout, lowest bit first; the opcode travels on tuser
    localparam int ADDR_LSB   = 0;
    localparam int VALUE_LSB  = ADDR_LSB + ADDR_W;
    localparam int PHASE_LSB  = VALUE_LSB + SAMPLE_W;
    localparam int S_USED_W   = PHASE_LSB + PHASE_W;
    localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;
    localparam int S_TUSER_W  = OPCODE_W;
    localparam int M_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } opcode_t;

endpackage

### hw/rtl/qwti_fold.sv
// folds a full-cycle index onto the quarter table: position and negate flag
`timescale 1ns / 1ps

module qwti_fold #(
    parameter int QUARTER_LEN = 256,
    parameter int CYC_W       = 10,
    parameter int POS_W       = 9
) (
    input  logic [CYC_W-1:0] idx,
    output logic [POS_W-1:0] pos,
    output logic             neg
);
    localparam logic [CYC_W-1:0] L1 = CYC_W'(QUARTER_LEN);
    localparam logic [CYC_W-1:0] L2 = CYC_W'(2 * QUARTER_LEN);
    localparam logic [CYC_W-1:0] L3 = CYC_W'(3 * QUARTER_LEN);
    // wraps to zero when the cycle is a power of two, still right modulo 2^CYC_W
    localparam logic [CYC_W-1:0] L4 = CYC_W'(4 * QUARTER_LEN);

    logic [CYC_W-1:0] pos_full;

    always_comb begin
        if (idx <= L1) begin
            pos_full = idx;
            neg      = 1'b0;
        end else if (idx <= L2) begin
            pos_full = L2 - idx;
            neg      = 1'b0;
        end else if (idx <= L3) begin
            pos_full = idx - L2;
            neg      = 1'b1;
        end else begin
            pos_full = L4 - idx;
            neg      = 1'b1;
        end
    end

    assign pos = POS_W'(pos_full);

endmodule

### hw/rtl/qwti_table.sv
// quarter-wave sample memory, one write port and two registered read ports
`timescale 1ns / 1ps

module qwti_table #(
    parameter int DEPTH = 257,
    parameter int AW    = 9
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  qwti_pkg::sample_t wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr_a,
    input  logic [AW-1:0]    rd_addr_b,
    output qwti_pkg::sample_t rd_data_a,
    output qwti_pkg::sample_t rd_data_b
);
    import qwti_pkg::*;

    sample_t mem [DEPTH];
    sample_t rd_a_reg;
    sample_t rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

### hw/rtl/qwti_interp.sv
// applies the quadrant sign and interpolates between the two samples
`timescale 1ns / 1ps

module qwti_interp #(
    parameter int FRAC_BITS = 14
) (
    input  qwti_pkg::sample_t    raw_a,
    input  qwti_pkg::sample_t    raw_b,
    input  logic                 neg_a,
    input  logic                 neg_b,
    input  logic [FRAC_BITS-1:0] frac,
    output qwti_pkg::sample_t    sample
);
    import qwti_pkg::*;

    localparam int PROD_W = FRAC_BITS + SAMPLE_W + 2;

    function automatic sample_t sat_neg(input sample_t v);
        sample_t r;
        // the most negative code has no positive twin
        if (v == {1'b1, {(SAMPLE_W-1){1'b0}}}) begin
            r = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else begin
            r = -v;
        end
        return r;
    endfunction

    sample_t                   s1;
    sample_t                   s2;
    logic signed [SAMPLE_W:0]  diff;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  prod_sh;
    logic signed [SAMPLE_W:0]  sum;

    assign s1   = neg_a ? sat_neg(raw_a) : raw_a;
    assign s2   = neg_b ? sat_neg(raw_b) : raw_b;
    assign diff = (SAMPLE_W+1)'(s2) - (SAMPLE_W+1)'(s1);
    assign prod = $signed({1'b0, frac}) * diff;
    // arithmetic shift floors towards minus infinity
    assign prod_sh = prod >>> FRAC_BITS;
    assign sum     = (SAMPLE_W+1)'(s1) + prod_sh[SAMPLE_W:0];
    // the result lies between s1 and s2, so it always fits
    assign sample  = sum[SAMPLE_W-1:0];

endmodule

### hw/rtl/quarter_wave_table_interpolator.sv
// top level of the quarter-wave table interpolator
`timescale 1ns / 1ps

// Quarter-wave table oscillator with linear interpolation. The block holds
// QUARTER_LEN+1 signed 16-bit samples of one quarter period. The opcode of
// an input word travels on s_tuser. An input word with opcode write stores
// entry_value at entry_address (addresses above QUARTER_LEN are dropped) and
// gives no output word; an input word with opcode read takes phase, splits
// it into a full-cycle index (bits above FRAC_BITS, reduced modulo
// 4*QUARTER_LEN) and a FRAC_BITS-bit fraction, folds the index and its
// wrapped successor onto the table (mirror in the second and fourth
// quadrants, saturating negation in the third and fourth) and returns
// s1 + floor(frac*(s2-s1)/2^FRAC_BITS). One word is taken every clock cycle
// unless a read held in the input register waits on a stalled output; a read
// passes the input register (reciprocal multiply for the index reduction
// ahead of it), the memory read register and the output register. The table
// has no reset and needs no clearing pass: an entry must be written before
// it is read.
module quarter_wave_table_interpolator #(
    parameter int QUARTER_LEN = 256,
    parameter int FRAC_BITS   = 14
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // entry_address, entry_value, phase, zero fill
    input  logic [qwti_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode
    input  logic [qwti_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // sample
    output logic [qwti_pkg::M_TDATA_W-1:0] m_tdata
);
    import qwti_pkg::*;

    localparam int TBL_DEPTH = QUARTER_LEN + 1;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int CYC_LEN   = 4 * QUARTER_LEN;
    localparam int CYC_W     = $clog2(CYC_LEN);
    localparam int IDX_W     = (PHASE_W > FRAC_BITS) ? PHASE_W - FRAC_BITS : 1;
    // floor(x / CYC_LEN) as (x * RECIP_M) >> RECIP_SH, exact for x < 2^IDX_W
    localparam int RECIP_SH  = IDX_W + CYC_W;
    localparam int M_W       = IDX_W + 2;
    localparam logic [63:0] RECIP_M =
        ((64'd1 << RECIP_SH) + 64'(CYC_LEN) - 64'd1) / 64'(CYC_LEN);
    localparam int RPROD_W   = IDX_W + M_W;
    localparam int RED_W     = IDX_W + CYC_W;

    // input word fields
    opcode_t              in_op;
    logic [ADDR_W-1:0]    in_addr;
    sample_t              in_value;
    logic [PHASE_W-1:0]   in_phase;
    logic [IDX_W-1:0]     in_idx;
    logic [RPROD_W-1:0]   recip_prod;

    assign in_op    = opcode_t'(s_tuser[OPCODE_W-1:0]);
    assign in_addr  = s_tdata[ADDR_LSB +: ADDR_W];
    assign in_value = sample_t'(s_tdata[VALUE_LSB +: SAMPLE_W]);
    assign in_phase = s_tdata[PHASE_LSB +: PHASE_W];
    assign in_idx   = IDX_W'(in_phase >> FRAC_BITS);
    assign recip_prod = RPROD_W'(in_idx) * RPROD_W'(RECIP_M);

    // stage 0: input register
    logic                 st0_valid_reg;
    opcode_t              st0_op_reg;
    logic [ADDR_W-1:0]    st0_addr_reg;
    sample_t              st0_value_reg;
    logic [FRAC_BITS-1:0] st0_frac_reg;
    logic [IDX_W-1:0]     st0_idx_reg;
    logic [IDX_W-1:0]     st0_quot_reg;

    // stage 1: memory read data plus sideband
    logic                 st1_valid_reg;
    logic                 st1_neg_a_reg;
    logic                 st1_neg_b_reg;
    logic [FRAC_BITS-1:0] st1_frac_reg;

    // output register
    logic                 out_valid_reg;
    sample_t              out_sample_reg;

    // flow control
    logic s_accept;
    logic out_load;    // output register may take a new word
    logic st1_load;    // stage 1 may take a new word
    logic st0_move;    // stage 0 word leaves this cycle

    assign out_load = !out_valid_reg || m_tready;
    assign st1_load = !st1_valid_reg || out_load;
    assign st0_move = st0_valid_reg && ((st0_op_reg == OP_WRITE) || st1_load);
    assign s_tready = !st0_valid_reg || st0_move;
    assign s_accept = s_tvalid && s_tready;

    // index reduction and fold
    logic [RED_W-1:0]   red_full;
    logic [CYC_W-1:0]   idx_a;
    logic [CYC_W-1:0]   idx_b;
    logic [TBL_AW-1:0]  pos_a;
    logic [TBL_AW-1:0]  pos_b;
    logic               neg_a;
    logic               neg_b;

    assign red_full = RED_W'(st0_idx_reg) - RED_W'(st0_quot_reg) * RED_W'(CYC_LEN);
    assign idx_a    = red_full[CYC_W-1:0];
    // successor wraps from the last index of the cycle back to zero
    assign idx_b    = (idx_a == CYC_W'(CYC_LEN - 1)) ? '0 : idx_a + CYC_W'(1);

    qwti_fold #(
        .QUARTER_LEN (QUARTER_LEN),
        .CYC_W       (CYC_W),
        .POS_W       (TBL_AW)
    ) u_fold_a (
        .idx (idx_a),
        .pos (pos_a),
        .neg (neg_a)
    );

    qwti_fold #(
        .QUARTER_LEN (QUARTER_LEN),
        .CYC_W       (CYC_W),
        .POS_W       (TBL_AW)
    ) u_fold_b (
        .idx (idx_b),
        .pos (pos_b),
        .neg (neg_b)
    );

    // table access from stage 0
    logic    addr_ok;
    logic    tbl_wr_en;
    logic    tbl_rd_en;
    sample_t rd_a;
    sample_t rd_b;

    assign addr_ok   = 32'(st0_addr_reg) <= 32'(QUARTER_LEN);
    assign tbl_wr_en = st0_move && (st0_op_reg == OP_WRITE) && addr_ok;
    assign tbl_rd_en = st0_move && (st0_op_reg == OP_READ);

    qwti_table #(
        .DEPTH (TBL_DEPTH),
        .AW    (TBL_AW)
    ) u_table (
        .aclk      (aclk),
        .wr_en     (tbl_wr_en),
        .wr_addr   (TBL_AW'(st0_addr_reg)),
        .wr_data   (st0_value_reg),
        .rd_en     (tbl_rd_en),
        .rd_addr_a (pos_a),
        .rd_addr_b (pos_b),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    // interpolation from stage 1 into the output register
    sample_t interp_sample;

    qwti_interp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_interp (
        .raw_a  (rd_a),
        .raw_b  (rd_b),
        .neg_a  (st1_neg_a_reg),
        .neg_b  (st1_neg_b_reg),
        .frac   (st1_frac_reg),
        .sample (interp_sample)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st0_valid_reg <= 1'b0;
            st1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                st0_valid_reg <= s_tvalid;
            end
            // write words end in stage 0 and never reach stage 1
            if (st1_load) begin
                st1_valid_reg <= st0_valid_reg && (st0_op_reg == OP_READ);
            end
            if (out_load) begin
                out_valid_reg <= st1_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st0_op_reg    <= in_op;
            st0_addr_reg  <= in_addr;
            st0_value_reg <= in_value;
            st0_frac_reg  <= in_phase[FRAC_BITS-1:0];
            st0_idx_reg   <= in_idx;
            st0_quot_reg  <= IDX_W'(recip_prod >> RECIP_SH);
        end
        if (tbl_rd_en) begin
            st1_neg_a_reg <= neg_a;
            st1_neg_b_reg <= neg_b;
            st1_frac_reg  <= st0_frac_reg;
        end
        if (out_load && st1_valid_reg) begin
            out_sample_reg <= interp_sample;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_sample_reg);

`ifndef SYNTHESIS
    // reset empties every stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !st0_valid_reg && !st1_valid_reg && !out_valid_reg)
        else $error("pipeline not empty after reset");

    // a write word leaving stage 0 never shows up in stage 1
    a_write_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        st0_move && (st0_op_reg == OP_WRITE) && st1_load |=> !st1_valid_reg)
        else $error("write word reached the read path");

    // a finished read moves into the output register
    a_read_delivered: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_valid_reg && out_load |=> m_tvalid)
        else $error("read word lost between stage 1 and output");

    // with all stages full and the output stalled nothing is taken
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        st0_valid_reg && (st0_op_reg == OP_READ) && st1_valid_reg &&
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while pipeline is full");
`endif

endmodule
